@@ rtl/rtb_pkg.sv @@
// Package for the RGB threshold bit packer.
// Holds register codes, reset values, widths and the item passed from front to back.
package rtb_pkg;

    localparam int CFG_DIM_W    = 13;
    localparam int CFG_THR_W    = 9;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 2;
    localparam int PIX_W        = 8;
    localparam int SUM_W        = 15;
    localparam int LIM_W        = 16;
    localparam int FILL_W       = 3;
    localparam int QUEUE_DEPTH  = 4;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam logic [CFG_DIM_W-1:0] RST_WIDTH  = 13'd1728;
    localparam logic [CFG_DIM_W-1:0] RST_HEIGHT = 13'd1;
    localparam logic [CFG_THR_W-1:0] RST_THR    = 9'd128;

    localparam logic [SUM_W-1:0] COEF_R  = 15'd30;
    localparam logic [SUM_W-1:0] COEF_G  = 15'd59;
    localparam logic [SUM_W-1:0] COEF_B  = 15'd11;
    localparam logic [LIM_W-1:0] THR_SCALE = 16'd100;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_THRESHOLD    = 2'd2,
        CFG_UNUSED       = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic              black;
        logic              emit;
        logic              row_end;
        logic              image_end;
        logic [FILL_W-1:0] fill;
    } t_item;

endpackage

@@ rtl/rtb_front.sv @@
// Front part: configuration registers, gray-level threshold and raster position.
// Classifies each accepted pixel into an rtb_pkg::t_item; depends on rtb_pkg.
module rtb_front #(
    parameter int MAX_WIDTH  = rtb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rtb_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rtb_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [rtb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_accept,
    input  logic [rtb_pkg::PIX_W-1:0]         i_red,
    input  logic [rtb_pkg::PIX_W-1:0]         i_green,
    input  logic [rtb_pkg::PIX_W-1:0]         i_blue,
    output rtb_pkg::t_item                    o_item
);
    import rtb_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = ($clog2(MAX_HEIGHT) > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WCW = ($clog2(MAX_WIDTH + 1) > CFG_DIM_W) ? $clog2(MAX_WIDTH + 1) : CFG_DIM_W;
    localparam int HCW = ($clog2(MAX_HEIGHT + 1) > CFG_DIM_W) ? $clog2(MAX_HEIGHT + 1) : CFG_DIM_W;

    logic [CFG_DIM_W-1:0] r_width, r_height;
    logic [CFG_THR_W-1:0] r_thr;
    logic [CW-1:0]        r_col, n_col;
    logic [RW-1:0]        r_row, n_row;

    logic [WCW-1:0]   width_eff, next_col;
    logic [HCW-1:0]   height_eff, next_row;
    logic [SUM_W-1:0] sum;
    logic [LIM_W-1:0] lim;
    logic             row_done, image_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_thr    <= RST_THR;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                CFG_THRESHOLD:    r_thr    <= i_cfg_data[CFG_THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_width == '0) begin
            width_eff = WCW'(1);
        end else if (WCW'(r_width) > WCW'(MAX_WIDTH)) begin
            width_eff = WCW'(MAX_WIDTH);
        end else begin
            width_eff = WCW'(r_width);
        end
        if (r_height == '0) begin
            height_eff = HCW'(1);
        end else if (HCW'(r_height) > HCW'(MAX_HEIGHT)) begin
            height_eff = HCW'(MAX_HEIGHT);
        end else begin
            height_eff = HCW'(r_height);
        end

        sum = COEF_R * SUM_W'(i_red) + COEF_G * SUM_W'(i_green) + COEF_B * SUM_W'(i_blue);
        lim = THR_SCALE * LIM_W'(r_thr);

        next_col   = WCW'(r_col) + WCW'(1);
        next_row   = HCW'(r_row) + HCW'(1);
        row_done   = next_col >= width_eff;
        image_done = row_done && (next_row >= height_eff);

        n_col = r_col;
        n_row = r_row;
        if (i_accept) begin
            if (row_done) begin
                n_col = '0;
                n_row = image_done ? '0 : RW'(next_row);
            end else begin
                n_col = CW'(next_col);
            end
        end

        o_item.black     = LIM_W'(sum) < lim;
        o_item.emit      = row_done || (r_col[FILL_W-1:0] == '1);
        o_item.row_end   = row_done;
        o_item.image_end = image_done;
        o_item.fill      = r_col[FILL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

@@ rtl/rtb_queue.sv @@
// Short flop queue of classified items between front and back.
// Depends on rtb_pkg for the item type.
module rtb_queue #(
    parameter int DEPTH = rtb_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rtb_pkg::t_item i_item,
    input  logic           i_pop,
    output rtb_pkg::t_item o_item,
    output logic           o_empty,
    output logic           o_full
);
    import rtb_pkg::*;

    localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [AW-1:0]  r_wr, r_rd;
    logic [NW-1:0]  r_cnt;
    logic           push_ok, pop_ok;

    assign o_empty = r_cnt == '0;
    assign o_full  = r_cnt == NW'(DEPTH);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (pop_ok) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            r_cnt <= r_cnt + NW'(push_ok) - NW'(pop_ok);
        end
    end

endmodule

@@ rtl/rtb_back.sv @@
// Back part: shifts pixel bits into the byte and drives the output register.
// Depends on rtb_pkg for the item type.
module rtb_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rtb_pkg::t_item            i_item,
    input  logic                      i_item_valid,
    output logic                      o_pop,
    output logic [rtb_pkg::PIX_W-1:0] o_packed_bits,
    output logic                      o_row_end,
    output logic                      o_image_end,
    output logic                      o_valid,
    input  logic                      i_stall
);
    import rtb_pkg::*;

    logic [PIX_W-1:0]  r_acc, acc_new;
    logic              r_valid, out_free;
    logic [FILL_W-1:0] shamt;

    assign out_free = !r_valid || !i_stall;
    assign o_pop    = i_item_valid && (!i_item.emit || out_free);
    assign acc_new  = {r_acc[PIX_W-2:0], i_item.black};
    assign shamt    = ~i_item.fill;
    assign o_valid  = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_acc <= i_item.emit ? '0 : acc_new;
            end
            if (o_pop && i_item.emit) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.emit) begin
            o_packed_bits <= acc_new << shamt;
            o_row_end     <= i_item.row_end;
            o_image_end   <= i_item.image_end;
        end
    end

endmodule

@@ rtl/rgb_threshold_bit_packer.sv @@
// Top level of the RGB threshold bit packer: front, item queue and back.
// Depends on rtb_pkg, rtb_front, rtb_queue and rtb_back.
//
// Takes one RGB pixel per clock in raster order while o_stall is low and emits
// one byte per eight pixels of a row, zero-padding the last byte of a row that
// ends short of a byte; bytes are flagged with row_end and image_end. A pixel
// is black (1) when 30*R + 59*G + 11*B is below 100*threshold. Sustained rate
// is one pixel per cycle while the output is not stalled; a pixel is held in a
// queue entry, then in the registered byte of the back. A four-entry queue
// decouples input and output; o_stall rises only after output stalls fill it.
module rgb_threshold_bit_packer #(
    parameter int MAX_WIDTH  = rtb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rtb_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rtb_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [rtb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [rtb_pkg::PIX_W-1:0]       i_red,
    input  logic [rtb_pkg::PIX_W-1:0]       i_green,
    input  logic [rtb_pkg::PIX_W-1:0]       i_blue,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [rtb_pkg::PIX_W-1:0]       o_packed_bits,
    output logic                            o_row_end,
    output logic                            o_image_end
);
    import rtb_pkg::*;

    t_item front_item, head_item;
    logic  accept, q_full, q_empty, pop;

    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    rtb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .o_item      (front_item)
    );

    rtb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    rtb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (head_item),
        .i_item_valid  (!q_empty),
        .o_pop         (pop),
        .o_packed_bits (o_packed_bits),
        .o_row_end     (o_row_end),
        .o_image_end   (o_image_end),
        .o_valid       (o_valid),
        .i_stall       (i_stall)
    );

endmodule

@@ rtl/rtb_checker.sv @@
// Port-level checks for rgb_threshold_bit_packer, with the bind that attaches them.
// Depends on rtb_pkg for port widths.
module rtb_assert (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_stall,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic [rtb_pkg::PIX_W-1:0]       o_packed_bits,
    input logic                            o_row_end,
    input logic                            o_image_end
);

    a_image_end_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_row_end || !o_image_end))
        else $error("image_end without row_end");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("reset left output valid or input stalled");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_packed_bits)
            && $stable(o_row_end) && $stable(o_image_end)))
        else $error("stalled output byte changed");

    a_stall_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(i_valid && !o_stall))
        else $error("input stall rose without an input transfer");

endmodule

bind rgb_threshold_bit_packer rtb_assert u_rtb_assert (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_packed_bits (o_packed_bits),
    .o_row_end     (o_row_end),
    .o_image_end   (o_image_end)
);

@@ bench/rtb_checker.sv @@
// Scoreboard for the RGB threshold bit packer: follows register writes and pixel
// transfers, predicts each packed byte and compares it with the output channel.
// Depends on rtb_pkg for the register index codes and reset values.
module rtb_checker
    import rtb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic [PIX_W-1:0]       i_red,
    input  logic [PIX_W-1:0]       i_green,
    input  logic [PIX_W-1:0]       i_blue,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic [PIX_W-1:0]       i_packed_bits,
    input  logic                   i_row_end,
    input  logic                   i_image_end,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_byte_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] bits;
        logic       row_end;
        logic       image_end;
    } t_packed_byte;

    t_packed_byte     byte_queue[$];
    logic [12:0]      width_reg  = RST_WIDTH;
    logic [12:0]      height_reg = RST_HEIGHT;
    logic [8:0]       thr_reg    = RST_THR;
    logic [7:0]       bit_acc    = '0;
    logic [11:0]      col_pos    = '0;
    logic [11:0]      row_pos    = '0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_byte_count = 0;
    end

    function automatic logic [12:0] clamp_dim(logic [12:0] v, int maxv);
        if (v == 0) return 13'd1;
        if (v > maxv) return 13'(maxv);
        return v;
    endfunction

    task automatic note_failure(input string msg);
        o_fail_count++;
        if (o_fail_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic pack_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        logic [12:0]  w;
        logic [12:0]  h;
        logic [12:0]  next_col;
        logic [12:0]  next_row;
        logic [15:0]  sum;
        logic [15:0]  limit;
        logic [3:0]   nbits;
        logic         black;
        logic         row_done;
        t_packed_byte e;
        w        = clamp_dim(width_reg, MAX_WIDTH);
        h        = clamp_dim(height_reg, MAX_HEIGHT);
        sum      = 16'(30 * r + 59 * g + 11 * b);
        limit    = 16'(100 * thr_reg);
        black    = sum < limit;
        next_col = {1'b0, col_pos} + 13'd1;
        nbits    = {1'b0, col_pos[2:0]} + 4'd1;
        row_done = next_col >= w;
        bit_acc  = {bit_acc[6:0], black};
        if (!row_done && nbits != 4'd8) begin
            col_pos = next_col[11:0];
            return;
        end
        e.bits      = bit_acc << (4'd8 - nbits);
        e.row_end   = row_done;
        e.image_end = 1'b0;
        bit_acc     = '0;
        if (row_done) begin
            col_pos  = '0;
            next_row = {1'b0, row_pos} + 13'd1;
            if (next_row >= h) begin
                e.image_end = 1'b1;
                row_pos     = '0;
            end else begin
                row_pos = next_row[11:0];
            end
        end else begin
            col_pos = next_col[11:0];
        end
        byte_queue.push_back(e);
    endtask

    always @(posedge i_clk) begin : monitor
        t_packed_byte e;
        if (!i_rst_n) begin
            width_reg  = RST_WIDTH;
            height_reg = RST_HEIGHT;
            thr_reg    = RST_THR;
            bit_acc    = '0;
            col_pos    = '0;
            row_pos    = '0;
            byte_queue.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_IMAGE_WIDTH:  width_reg  = i_cfg_data[12:0];
                    CFG_IMAGE_HEIGHT: height_reg = i_cfg_data[12:0];
                    CFG_THRESHOLD:    thr_reg    = i_cfg_data[8:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) pack_pixel(i_red, i_green, i_blue);
            if (i_out_valid !== 1'b0 && i_out_stall === 1'b0) begin
                o_byte_count++;
                if (byte_queue.size() == 0) begin
                    note_failure($sformatf("unexpected byte %02h row_end %b image_end %b",
                                           i_packed_bits, i_row_end, i_image_end));
                end else begin
                    e = byte_queue.pop_front();
                    if (i_out_valid !== 1'b1 || i_packed_bits !== e.bits ||
                        i_row_end !== e.row_end || i_image_end !== e.image_end)
                        note_failure($sformatf(
                            "expected %02h/%b/%b, got %02h/%b/%b (valid %b)",
                            e.bits, e.row_end, e.image_end,
                            i_packed_bits, i_row_end, i_image_end, i_out_valid));
                end
            end
        end
        o_pending = byte_queue.size();
    end

endmodule

@@ bench/tb_top.sv @@
// Top of the RGB threshold bit packer bench: clock, reset, register writes and
// pixel stimulus under three idle profiles. Depends on rtb_pkg, rtb_checker and
// the rgb_threshold_bit_packer RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rtb_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 12;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;
    logic                   in_valid    = 1'b0;
    logic                   in_stall;
    logic [PIX_W-1:0]       red         = '0;
    logic [PIX_W-1:0]       green       = '0;
    logic [PIX_W-1:0]       blue        = '0;
    logic                   out_valid;
    logic                   out_stall   = 1'b0;
    logic [PIX_W-1:0]       packed_bits;
    logic                   row_end;
    logic                   image_end;

    int          fail_count;
    int          pending;
    int          byte_count;
    int          cycles        = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int unsigned n_sent        = 0;
    logic [12:0] cur_width     = RST_WIDTH;
    logic [12:0] cur_height    = RST_HEIGHT;
    logic [8:0]  cur_thr       = RST_THR;

    rgb_threshold_bit_packer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_valid       (in_valid),
        .o_stall       (in_stall),
        .i_red         (red),
        .i_green       (green),
        .i_blue        (blue),
        .o_valid       (out_valid),
        .i_stall       (out_stall),
        .o_packed_bits (packed_bits),
        .o_row_end     (row_end),
        .o_image_end   (image_end)
    );

    rtb_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_red         (red),
        .i_green       (green),
        .i_blue        (blue),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_packed_bits (packed_bits),
        .i_row_end     (row_end),
        .i_image_end   (image_end),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_byte_count  (byte_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still expected", cycles, pending);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int eff_dim(logic [12:0] v);
        if (v == 0) return 1;
        if (v > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
        return int'(v);
    endfunction

    // drop valid, drain the pipeline, then write one register
    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] val);
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_IMAGE_WIDTH:  cur_width  = val;
            CFG_IMAGE_HEIGHT: cur_height = val;
            CFG_THRESHOLD:    cur_thr    = val[8:0];
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        red      <= r;
        green    <= g;
        blue     <= b;
        do @(posedge i_clk); while (in_stall);
        n_sent++;
    endtask

    task automatic send_random_pixel();
        int sel;
        int v;
        sel = $urandom_range(99);
        if (sel < 45) begin
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        end else if (sel < 70) begin
            // gray right at the threshold boundary
            v = int'(cur_thr) - 2 + int'($urandom_range(3));
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            send_pixel(8'(v), 8'(v), 8'(v));
        end else if (sel < 85) begin
            send_pixel(8'($urandom_range(1) * 255), 8'($urandom_range(1) * 255),
                       8'($urandom_range(1) * 255));
        end else begin
            send_pixel(8'($urandom_range(1) * 255), 8'($urandom),
                       8'($urandom_range(1) * 255));
        end
    endtask

    task automatic run_phase(input int sidle, input int ridle, input int budget);
        int          start;
        int          sel;
        int          count;
        int          left;
        logic [12:0] wv;
        logic [12:0] hv;
        logic [8:0]  tv;
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        start = int'(n_sent);
        while (int'(n_sent) - start < budget) begin
            // keep dimensions now and then so counters carry across writes
            if ($urandom_range(3) != 0) begin
                sel = $urandom_range(99);
                if (sel < 70)      wv = 13'($urandom_range(1, 16));
                else if (sel < 90) wv = 13'($urandom_range(17, 64));
                else if (sel < 95) wv = 13'd0;
                else               wv = 13'($urandom_range(65, 200));
                sel = $urandom_range(99);
                if (sel < 60)      hv = 13'($urandom_range(1, 3));
                else if (sel < 85) hv = 13'($urandom_range(4, 8));
                else if (sel < 95) hv = 13'd0;
                else               hv = 13'($urandom_range(8191));
                write_reg(CFG_IMAGE_WIDTH, wv);
                write_reg(CFG_IMAGE_HEIGHT, hv);
            end
            sel = $urandom_range(99);
            if (sel < 15)      tv = 9'd0;
            else if (sel < 30) tv = 9'd256;
            else if (sel < 40) tv = 9'($urandom_range(257, 511));
            else               tv = 9'($urandom_range(1, 255));
            write_reg(CFG_THRESHOLD, {4'($urandom), tv});
            if ($urandom_range(99) < 80) begin
                count = eff_dim(cur_width) * eff_dim(cur_height);
                if (count > 300) count = 300;
            end else begin
                count = $urandom_range(1, 40);
            end
            left = budget - (int'(n_sent) - start);
            if (count > left) count = left;
            repeat (count) send_random_pixel();
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 18;
        recv_idle_pct = 60;

        // zero width acts as one, zero threshold makes every pixel white
        write_reg(CFG_IMAGE_WIDTH, 13'd0);
        write_reg(CFG_IMAGE_HEIGHT, 13'd1);
        write_reg(CFG_THRESHOLD, 13'd0);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        write_reg(CFG_THRESHOLD, 13'd256);
        send_pixel(8'd255, 8'd255, 8'd255);
        // threshold above 256, upper data bits must be ignored
        write_reg(CFG_THRESHOLD, 13'h1FFF);
        send_pixel(8'd255, 8'd255, 8'd255);
        write_reg(CFG_UNUSED, 13'h1555);

        // two rows of three, gray boundary and single channels
        write_reg(CFG_IMAGE_WIDTH, 13'd3);
        write_reg(CFG_IMAGE_HEIGHT, 13'd2);
        write_reg(CFG_THRESHOLD, 13'd100);
        send_pixel(8'd99, 8'd99, 8'd99);
        send_pixel(8'd100, 8'd100, 8'd100);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);

        // shrink width and height mid-image: counters are kept
        write_reg(CFG_IMAGE_WIDTH, 13'd10);
        write_reg(CFG_IMAGE_HEIGHT, 13'h1FFF);
        repeat (5) send_pixel(8'd0, 8'd0, 8'd0);
        write_reg(CFG_IMAGE_WIDTH, 13'd3);
        send_pixel(8'd255, 8'd255, 8'd255);
        write_reg(CFG_IMAGE_HEIGHT, 13'd1);
        write_reg(CFG_IMAGE_WIDTH, 13'd1);
        send_pixel(8'd10, 8'd20, 8'd30);

        // one full byte, alternating black and white
        write_reg(CFG_IMAGE_WIDTH, 13'd8);
        write_reg(CFG_THRESHOLD, 13'd128);
        for (int i = 0; i < 8; i++) begin
            if (i % 2 == 0) send_pixel(8'd0, 8'd0, 8'd0);
            else            send_pixel(8'd255, 8'd255, 8'd255);
        end

        run_phase(18, 60, 220);
        run_phase(60, 18, 220);
        run_phase(0, 0, 200);

        // width above the maximum, open row left at the end of the run
        write_reg(CFG_IMAGE_WIDTH, 13'h1FFF);
        write_reg(CFG_IMAGE_HEIGHT, 13'd1);
        write_reg(CFG_THRESHOLD, 13'd128);
        repeat (40) send_random_pixel();

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("covered %0d pixels and %0d packed bytes under three idle profiles,",
                 n_sent, byte_count);
        $display("widths and heights 0..8191, thresholds 0..511, mid-image register changes");
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/rtb_pkg.sv
rtl/rtb_front.sv
rtl/rtb_queue.sv
rtl/rtb_back.sv
rtl/rgb_threshold_bit_packer.sv
rtl/rtb_checker.sv
bench/rtb_checker.sv
bench/tb_top.sv
